// ===== rtl/ofsc_pkg.sv =====
// Shared widths and constants for the octant-folded sine/cosine block.
package ofsc_pkg;

  localparam int AngleW   = 16;   // input angle, 65536 units per turn
  localparam int OutW     = 18;   // signed Q16 results
  localparam int MagW     = 14;   // |x| after octant folding, up to 8192
  localparam int RootBits = 17;   // sqrt result bits, also multiplier operand width
  localparam int ProdW    = 2 * RootBits;   // shift-add product register
  localparam int DivBits  = 27;   // bits of x*x fed through the divider
  localparam int QuotW    = 15;   // x*x / 3448 stays below 2^15
  localparam int DivRemW  = 12;   // remainder of division by 3448
  localparam int CntW     = 5;    // iteration counter, covers DivBits

  localparam logic [DivRemW-1:0]  ParabolaDiv = 12'd3448;
  localparam logic [RootBits-1:0] OneQ16      = 17'h10000;

endpackage

// ===== rtl/ofsc_sqrt.sv =====
// Digit-by-digit square root, two radicand bits shifted in per cycle.
module ofsc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [ofsc_pkg::RootBits-1:0] rad_hi_i,
  output logic [ofsc_pkg::RootBits-1:0] root_o,
  output logic                          done_o
);
  import ofsc_pkg::*;

  localparam int RadW = 2 * RootBits;
  localparam int RemW = RootBits + 2;
  localparam int TryW = RootBits + 4;

  logic [RadW-1:0]     r_q, r_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootBits-1:0] root_q, root_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [TryW-1:0]     rem_t, trial;
  logic                ge;

  assign rem_t = {rem_q, r_q[RadW-1:RadW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = (rem_t >= trial);

  always_comb begin
    r_d    = r_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (load_i) begin
      // radicand is (1 - cc) << 16, so the low 16 bits are all zeros
      r_d    = {1'b0, rad_hi_i, {(RootBits-1){1'b0}}};
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d    = {r_q[RadW-3:0], 2'b00};
      rem_d  = ge ? RemW'(rem_t - trial) : rem_t[RemW-1:0];
      root_d = {root_q[RootBits-2:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> busy_q)
    else $error("sqrt did not start after load");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("sqrt done without a finished run");

endmodule

// ===== rtl/octant_folded_sine_cosine.sv =====
// Octant-folded sine/cosine in Q16: bit-serial square, divide, square and sqrt.
//
//   port group                      dir  beat marked by
//   start / angle_i                 in   start && !busy
//   valid_o / cos_value_o, sin_...  out  valid_o, one cycle, no back-pressure
//
// An item runs 17 shift-add steps for x*x, 27 restoring divide steps by
// 3448, the prep state, 17 steps for c*c and 17 square-root steps, with
// handoffs via sqrt_go_q and the sqrt done flag. valid_o pulses as busy
// drops, so a start held in that cycle is taken; none is taken while busy.
// Reset clears the sequencer; the receiver cannot stall, results are dropped
// if not taken in their strobe cycle.
module octant_folded_sine_cosine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic signed [ofsc_pkg::AngleW-1:0]  angle_i,
  output logic                                busy,
  output logic                                valid_o,
  output logic signed [ofsc_pkg::OutW-1:0]    cos_value_o,
  output logic signed [ofsc_pkg::OutW-1:0]    sin_value_o
);
  import ofsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ProdW-1:0]    p_q, p_d;
  logic [RootBits-1:0] m_q, m_d;
  logic [DivRemW-1:0]  rem_q, rem_d;
  logic                swap_q, swap_d, neg_s_q, neg_s_d, neg_c_q, neg_c_d;
  logic                sqrt_go_q, sqrt_go_d;
  logic                valid_q, valid_d;
  logic [OutW-1:0]     cos_q, cos_d, sin_q, sin_d;

  logic                accept;
  logic [MagW-1:0]     mag;
  logic [RootBits:0]   mul_sum;
  logic [ProdW-1:0]    mul_next;
  logic [DivRemW:0]    div_trial;
  logic                div_ge;
  logic [RootBits-1:0] c_val, rad_hi, root, cos_pre, sin_pre;
  logic [OutW-1:0]     cos_ext, sin_ext;
  logic                sqrt_done;

  assign accept = start && !busy;

  // folded x is angle[13:0] read as signed; take its magnitude
  assign mag = angle_i[MagW-1] ? (MagW'(0) - angle_i[MagW-1:0]) : angle_i[MagW-1:0];

  // shift-add multiplier: add multiplicand on the low bit, shift right
  assign mul_sum  = {1'b0, p_q[ProdW-1:RootBits]} + (p_q[0] ? {1'b0, m_q} : '0);
  assign mul_next = {mul_sum, p_q[RootBits-1:1]};

  // restoring division: dividend shifts out the top, quotient bits in at the bottom
  assign div_trial = {rem_q, p_q[DivBits-1]};
  assign div_ge    = (div_trial >= {1'b0, ParabolaDiv});

  assign c_val  = OneQ16 - RootBits'(p_q[QuotW-1:0]);
  assign rad_hi = OneQ16 - p_q[ProdW-2:RootBits-1];

  ofsc_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (sqrt_go_q),
    .rad_hi_i (rad_hi),
    .root_o   (root),
    .done_o   (sqrt_done)
  );

  assign cos_pre = swap_q ? root : m_q;
  assign sin_pre = swap_q ? m_q : root;
  assign cos_ext = {1'b0, cos_pre};
  assign sin_ext = {1'b0, sin_pre};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    p_d       = p_q;
    m_d       = m_q;
    rem_d     = rem_q;
    swap_d    = swap_q;
    neg_s_d   = neg_s_q;
    neg_c_d   = neg_c_q;
    sqrt_go_d = 1'b0;
    valid_d   = 1'b0;
    cos_d     = cos_q;
    sin_d     = sin_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          p_d     = {{(ProdW-MagW){1'b0}}, mag};
          m_d     = RootBits'(mag);
          swap_d  = angle_i[14] ^ angle_i[13];
          neg_s_d = angle_i[15];
          neg_c_d = angle_i[15] ^ angle_i[14];
          cnt_d   = CntW'(RootBits - 1);
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        p_d   = mul_next;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = CntW'(DivBits - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        p_d   = {p_q[ProdW-1:DivBits], p_q[DivBits-2:0], div_ge};
        rem_d = div_ge ? DivRemW'(div_trial - {1'b0, ParabolaDiv})
                       : div_trial[DivRemW-1:0];
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        p_d     = {{(ProdW-RootBits){1'b0}}, c_val};
        m_d     = c_val;
        cnt_d   = CntW'(RootBits - 1);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p_d   = mul_next;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          sqrt_go_d = 1'b1;
          state_d   = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          cos_d   = neg_c_q ? (OutW'(0) - cos_ext) : cos_ext;
          sin_d   = neg_s_q ? (OutW'(0) - sin_ext) : sin_ext;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      sqrt_go_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      sqrt_go_q <= sqrt_go_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    m_q     <= m_d;
    rem_q   <= rem_d;
    swap_q  <= swap_d;
    neg_s_q <= neg_s_d;
    neg_c_q <= neg_c_d;
    cos_q   <= cos_d;
    sin_q   <= sin_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign cos_value_o = cos_q;
  assign sin_value_o = sin_q;

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_MUL1))
    else $error("accepted beat did not start the multiplier");

  a_valid_from_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(sqrt_done) && !busy))
    else $error("result strobe without a finished root");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < ParabolaDiv))
    else $error("divider remainder out of range");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cos_value_o <= 18'sd65536 && cos_value_o >= -18'sd65536 &&
                 sin_value_o <= 18'sd65536 && sin_value_o >= -18'sd65536))
    else $error("result outside unit range");

endmodule

// ===== tb/sv/octant_folded_sine_cosine_tb.sv =====
// Self-checking testbench for the octant-folded sine/cosine block.
`timescale 1ns / 100ps

module octant_folded_sine_cosine_tb;
  import ofsc_pkg::*;

  localparam logic [AngleW-1:0] FoldMask  = 16'hC000;
  localparam logic [AngleW-1:0] SwapBit   = 16'h4000;
  localparam logic [AngleW-1:0] NegCosBit = 16'h8000;
  localparam int NumDirected = 23;
  localparam int NumRandom   = 1250;
  localparam int DrainCycles = 120;

  typedef struct packed {
    logic [AngleW-1:0]      angle;
    logic signed [OutW-1:0] cos_v;
    logic signed [OutW-1:0] sin_v;
  } trig_pair_t;

  // typed_in marks rows whose result is written out here, the rest are predicted
  typedef struct packed {
    logic [AngleW-1:0]      angle;
    logic                   typed_in;
    logic signed [OutW-1:0] cos_v;
    logic signed [OutW-1:0] sin_v;
  } angle_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic signed [AngleW-1:0]      angle_i;
  logic                          busy;
  logic                          valid_o;
  logic signed [OutW-1:0]        cos_value_o;
  logic signed [OutW-1:0]        sin_value_o;

  trig_pair_t expected_q[$];
  trig_pair_t head_pair;
  int         mismatch_count = 0;
  bit         idling_on = 1'b1;

  angle_row_t directed_rows [NumDirected] = '{
    '{16'h0000, 1'b1,  18'sd65536,  18'sd0},
    '{16'h4000, 1'b1,  18'sd0,      18'sd65536},
    '{16'h8000, 1'b1, -18'sd65536,  18'sd0},
    '{16'hC000, 1'b1,  18'sd0,     -18'sd65536},
    '{16'h0001, 1'b0, '0, '0},
    '{16'hFFFF, 1'b0, '0, '0},
    '{16'h1FFF, 1'b0, '0, '0},
    '{16'h2000, 1'b0, '0, '0},
    '{16'h2001, 1'b0, '0, '0},
    '{16'hE000, 1'b0, '0, '0},
    '{16'hDFFF, 1'b0, '0, '0},
    '{16'h5FFF, 1'b0, '0, '0},
    '{16'h6000, 1'b0, '0, '0},
    '{16'hA000, 1'b0, '0, '0},
    '{16'h7FFF, 1'b0, '0, '0},
    '{16'h3FFF, 1'b0, '0, '0},
    '{16'h4001, 1'b0, '0, '0},
    '{16'hBFFF, 1'b0, '0, '0},
    '{16'h5555, 1'b0, '0, '0},
    '{16'hAAAA, 1'b0, '0, '0},
    '{16'h1000, 1'b0, '0, '0},
    '{16'hF000, 1'b0, '0, '0},
    '{16'h8001, 1'b0, '0, '0}
  };

  octant_folded_sine_cosine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .angle_i     (angle_i),
    .busy        (busy),
    .valid_o     (valid_o),
    .cos_value_o (cos_value_o),
    .sin_value_o (sin_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // fold to the octant around zero, parabola for cos, bitwise floor sqrt for sin
  function automatic trig_pair_t predict_cos_sin(input logic [AngleW-1:0] a);
    logic [AngleW-1:0] fold;
    logic signed [14:0] x15;
    longint x, c, s, cc, rad, root, cand, tmp;
    trig_pair_t r;
    fold = (a ^ (a << 1)) & FoldMask;
    x15  = a[14:0] + fold[14:0];
    x    = x15;
    c    = longint'(OneQ16) - (x * x) / longint'(ParabolaDiv);
    cc   = (c * c) >>> 16;
    rad  = (longint'(OneQ16) - cc) <<< 16;
    root = 0;
    for (int b = RootBits - 1; b >= 0; b--) begin
      cand = root | (64'sd1 <<< b);
      if (cand * cand <= rad) root = cand;
    end
    s = root;
    if ((fold & SwapBit) != 0) begin
      tmp = c;
      c   = s;
      s   = tmp;
    end
    if (a[AngleW-1]) s = -s;
    if ((fold & NegCosBit) != 0) c = -c;
    r.angle = a;
    r.cos_v = c[OutW-1:0];
    r.sin_v = s[OutW-1:0];
    return r;
  endfunction

  // mostly uniform, a quarter of them close to octant boundaries
  function automatic logic [AngleW-1:0] pick_angle();
    if ($urandom_range(0, 3) == 3)
      return AngleW'($urandom_range(0, 7) * 8192 + $urandom_range(0, 8) - 4);
    return AngleW'($urandom());
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // holds start high after the beat; only an idle gap or wait_drained lowers it
  task automatic send_angle(input logic [AngleW-1:0] a, input trig_pair_t exp_pair);
    if (idling_on && $urandom_range(0, 99) < 9) begin
      // gap is counted from the cycle the block frees up
      start <= 1'b0;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      repeat ($urandom_range(20, 160)) @(posedge clk_i);
    end
    start   <= 1'b1;
    angle_i <= a;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(exp_pair);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result cos=%0d sin=%0d with nothing expected",
                                  cos_value_o, sin_value_o));
      end else begin
        head_pair = expected_q.pop_front();
        if (cos_value_o !== head_pair.cos_v)
          report_mismatch($sformatf("angle %h cos got %0d want %0d",
                                    head_pair.angle, cos_value_o, head_pair.cos_v));
        if (sin_value_o !== head_pair.sin_v)
          report_mismatch($sformatf("angle %h sin got %0d want %0d",
                                    head_pair.angle, sin_value_o, head_pair.sin_v));
      end
    end
  end

  initial begin : stimulus
    logic [AngleW-1:0] a;
    trig_pair_t exp_pair;
    rst_ni  = 1'b0;
    start   <= 1'b0;
    angle_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed_in) begin
        exp_pair.angle = directed_rows[i].angle;
        exp_pair.cos_v = directed_rows[i].cos_v;
        exp_pair.sin_v = directed_rows[i].sin_v;
      end else begin
        exp_pair = predict_cos_sin(directed_rows[i].angle);
      end
      send_angle(directed_rows[i].angle, exp_pair);
    end
    wait_drained();

    for (int i = 0; i < NumRandom; i++) begin
      idling_on = !(i >= 400 && i < 700);
      if (i == 900) wait_drained();
      a = pick_angle();
      send_angle(a, predict_cos_sin(a));
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ofsc_pkg.sv
rtl/ofsc_sqrt.sv
rtl/octant_folded_sine_cosine.sv
tb/sv/octant_folded_sine_cosine_tb.sv
